FILE: rtl/fgps_pkg.sv
// shared types and constants of the filtered group-by profit accumulator
`default_nettype none

package fgps_pkg;

    // table geometry
    localparam int FGPS_TABLE_DEPTH = 1024;
    localparam int FGPS_IDX_W       = 10;
    localparam int FGPS_SUM_W       = 64;

    // queue between front and back
    localparam int FGPS_QUEUE_DEPTH = 4;

    // year window of the query
    localparam logic [15:0] FGPS_BASE_YEAR  = 16'd1997;
    localparam logic [15:0] FGPS_LAST_YEAR  = 16'd1998;
    localparam logic [10:0] FGPS_YEAR_OUT_0 = 11'd1997;

    // item functions
    localparam logic FGPS_FUNC_ACCUM = 1'b0;
    localparam logic FGPS_FUNC_READ  = 1'b1;

    // register indexes on the config port
    localparam logic [1:0] FGPS_REG_REGION  = 2'd0;
    localparam logic [1:0] FGPS_REG_MAKER_A = 2'd1;
    localparam logic [1:0] FGPS_REG_MAKER_B = 2'd2;

    typedef struct packed {
        logic        func;
        logic [7:0]  customer_region;
        logic [7:0]  supplier_region;
        logic [15:0] order_year;
        logic [7:0]  part_maker;
        logic [4:0]  supplier_nation;
        logic [3:0]  part_category;
        logic [31:0] revenue;
        logic [31:0] supply_cost;
        logic [9:0]  read_index;
    } t_in_beat;

    typedef struct packed {
        logic        entry_valid;
        logic [10:0] group_year;
        logic [4:0]  group_nation;
        logic [3:0]  group_category;
        logic [63:0] profit_sum;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] region_code;
        logic [7:0] maker_code_a;
        logic [7:0] maker_code_b;
    } t_cfg;

    // classified work item handed from front to back
    typedef struct packed {
        logic                  is_read;
        logic [FGPS_IDX_W-1:0] idx;
        logic [FGPS_SUM_W-1:0] diff;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_back_status;

endpackage

`default_nettype wire

FILE: rtl/fgps_front.sv
// front end: row filter, group index and profit difference
`default_nettype none

module fgps_front import fgps_pkg::*; (
    input  wire t_in_beat i_beat,
    input  wire t_cfg     i_cfg,
    output t_op           o_op,
    output logic          o_keep
);

    logic is_read;
    logic year_ok;
    logic maker_ok;
    logic region_ok;
    logic pass;

    always_comb begin
        is_read   = (i_beat.func == FGPS_FUNC_READ);
        year_ok   = (i_beat.order_year == FGPS_BASE_YEAR) ||
                    (i_beat.order_year == FGPS_LAST_YEAR);
        maker_ok  = (i_beat.part_maker == i_cfg.maker_code_a) ||
                    (i_beat.part_maker == i_cfg.maker_code_b);
        region_ok = (i_beat.customer_region == i_cfg.region_code) &&
                    (i_beat.supplier_region == i_cfg.region_code);
        pass      = year_ok && maker_ok && region_ok;

        o_op.is_read = is_read;
        if (is_read) begin
            o_op.idx = i_beat.read_index;
        end else begin
            o_op.idx = {(i_beat.order_year == FGPS_LAST_YEAR),
                        i_beat.supplier_nation, i_beat.part_category};
        end
        // wraps modulo 2^64 when cost exceeds revenue
        o_op.diff = {32'd0, i_beat.revenue} - {32'd0, i_beat.supply_cost};
        o_keep    = is_read || pass;
    end

endmodule

`default_nettype wire

FILE: rtl/fgps_queue.sv
// small fifo of classified ops between front and back
`default_nettype none

module fgps_queue import fgps_pkg::*; #(
    parameter int DEPTH = FGPS_QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  wire t_op      i_push_op,
    input  wire           i_pop,
    output t_op           o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

FILE: rtl/fgps_back.sv
// back end: group table memory, read-modify-write and result register
`default_nettype none

module fgps_back import fgps_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_op      i_head,
    input  wire           i_head_avail,
    output logic          o_pop,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output t_out_beat     o_out_beat,
    output t_back_status  o_status
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam int ENT_W = FGPS_SUM_W + 1;

    // entry: valid bit on top of the running sum
    logic [ENT_W-1:0]      r_table [FGPS_TABLE_DEPTH];
    logic [ENT_W-1:0]      r_rdata;

    logic [1:0]            r_state, n_state;
    logic [FGPS_IDX_W-1:0] r_clr_idx;
    t_op                   r_op;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out_beat;

    logic                  out_free;
    logic                  load_out;
    logic                  we;
    logic [FGPS_IDX_W-1:0] waddr;
    logic [ENT_W-1:0]      wdata;

    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        o_pop       = (r_state == S_IDLE) && i_head_avail;
        load_out    = (r_state == S_EXEC) && r_op.is_read && out_free;
        we          = 1'b0;
        waddr       = r_op.idx;
        wdata       = {1'b1, r_rdata[FGPS_SUM_W-1:0] + r_op.diff};
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_idx;
                wdata = '0;
                if (r_clr_idx == FGPS_IDX_W'(FGPS_TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_op.is_read) begin
                    we      = 1'b1;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + FGPS_IDX_W'(1);
            end
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[waddr] <= wdata;
        end
        if (o_pop) begin
            r_rdata <= r_table[i_head.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head;
        end
        if (load_out) begin
            r_out_beat.entry_valid    <= r_rdata[FGPS_SUM_W];
            r_out_beat.group_year     <= FGPS_YEAR_OUT_0 + 11'(r_op.idx[9]);
            r_out_beat.group_nation   <= r_op.idx[8:4];
            r_out_beat.group_category <= r_op.idx[3:0];
            r_out_beat.profit_sum     <= r_rdata[FGPS_SUM_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out_beat;
    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.busy     = (r_state == S_EXEC);

endmodule

`default_nettype wire

FILE: rtl/filtered_group_by_profit_sum.sv
// top level of the filtered group-by profit accumulator
`default_nettype none

// Filtered group-by profit accumulator. An accumulate beat (func 0) carries
// one joined fact row; it passes when both regions match region_code, the
// year is 1997 or 1998 and the maker matches maker_code_a or maker_code_b,
// and then revenue minus supply cost (wrapping at 64 bits) is added into the
// group table at index {year is 1998, nation, category}. A read beat (func 1)
// returns one table entry with its decoded year, nation and category and
// gives exactly one output beat; accumulate beats give none. Timing: after
// reset the table is cleared by a pass over all 1024 entries, one entry a cycle,
// during which o_in_stall is high (config writes still work). After that,
// rows that fail the filter are taken one per cycle and dropped while the
// queue has room; every read beat and every passing row goes through the
// back end as a registered table read followed by the write-back or the
// result load, never overlapped with the next op. A read beat also waits
// there for as long as a result beat sits stalled in the output register.
// A small queue lets the input keep streaming while the back end works or
// the output stalls; after the clear the input stalls only when it is full.
module filtered_group_by_profit_sum import fgps_pkg::*; #(
    parameter int QUEUE_DEPTH = FGPS_QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    // input beats
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_beat   i_in_beat,
    // result beats
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output t_out_beat       o_out_beat,
    // config port
    input  wire             psel,
    input  wire             penable,
    input  wire             pwrite,
    input  wire [3:0]       paddr,
    input  wire [31:0]      pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    t_cfg          r_cfg;
    t_op           front_op;
    logic          front_keep;
    logic          in_accept;
    logic          push;
    logic          pop;
    t_op           head;
    t_queue_status q_status;
    t_back_status  b_status;
    logic          cfg_write;

    // config registers, word per register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                FGPS_REG_REGION:  r_cfg.region_code  <= pwdata[7:0];
                FGPS_REG_MAKER_A: r_cfg.maker_code_a <= pwdata[7:0];
                FGPS_REG_MAKER_B: r_cfg.maker_code_b <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            FGPS_REG_REGION:  prdata = {24'd0, r_cfg.region_code};
            FGPS_REG_MAKER_A: prdata = {24'd0, r_cfg.maker_code_a};
            FGPS_REG_MAKER_B: prdata = {24'd0, r_cfg.maker_code_b};
            default:          prdata = '0;
        endcase
    end

    // front: filter and classify
    fgps_front u_front (
        .i_beat (i_in_beat),
        .i_cfg  (r_cfg),
        .o_op   (front_op),
        .o_keep (front_keep)
    );

    // hold input while the table clears or the queue is full
    assign o_in_stall = b_status.clearing || q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign push       = in_accept && front_keep;

    fgps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (front_op),
        .i_pop     (pop),
        .o_head    (head),
        .o_status  (q_status)
    );

    // back: table update and reads
    fgps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_avail (!q_status.empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_beat   (o_out_beat),
        .o_status     (b_status)
    );

    // no input beat is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_status.clearing |-> !in_accept)
        else $error("input beat accepted during table clear");

    // an entry never written reads back with zero sum
    a_invalid_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.entry_valid) |-> (o_out_beat.profit_sum == '0))
        else $error("invalid entry with nonzero sum");

    // decoded year stays in the query window
    a_year_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.group_year == FGPS_YEAR_OUT_0 ||
                         o_out_beat.group_year == FGPS_YEAR_OUT_0 + 11'd1))
        else $error("decoded year out of range");

    // queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: tb/tb_filtered_group_by_profit_sum.sv
`timescale 1ns / 100ps
// self-checking testbench of the filtered group-by profit accumulator
module tb_filtered_group_by_profit_sum;
    import fgps_pkg::*;

    // slowest correct run: clearing pass, about 1300 beats with input gaps,
    // back end work and output stalls
    localparam int CYCLE_LIMIT   = 200000;
    // back end queue holds 4 ops, rows give no result to wait on
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 256;

    // ways of breaking an otherwise passing row
    typedef enum logic [1:0] {
        BREAK_CUST,
        BREAK_SUPP,
        BREAK_YEAR,
        BREAK_MAKER
    } t_break;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_beat   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_beat;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    filtered_group_by_profit_sum u_dut (.*);

    // own copy of the group table and the filter registers
    logic        group_hit   [FGPS_TABLE_DEPTH];
    logic [63:0] group_total [FGPS_TABLE_DEPTH];
    t_cfg        filter_cfg;

    t_out_beat   expected_groups[$];   // reads accepted, result not yet seen
    t_in_beat    pending_beats[$];     // beats waiting for the driver

    // idling knobs, percent chance of a burst
    int gap_pct   = 0;
    int stall_pct = 0;
    int gap_left  = 0;
    int stall_left = 0;
    int stall_next;
    logic beat_taken = 1'b0;

    int cycle_count    = 0;
    int rows_seen      = 0;
    int rows_kept      = 0;
    int reads_seen     = 0;
    int groups_checked = 0;
    int mismatches     = 0;
    int settings_used  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor: fold one accepted beat into the table copy
    // ---------------------------------------------------------------------
    task automatic fold_beat(input t_in_beat b);
        logic [9:0] idx;
        t_out_beat  grp;
        if (b.func == FGPS_FUNC_ACCUM) begin
            rows_seen++;
            // both regions, the year window and either maker must match
            if (b.customer_region == filter_cfg.region_code
                    && b.supplier_region == filter_cfg.region_code
                    && (b.order_year == FGPS_BASE_YEAR || b.order_year == FGPS_LAST_YEAR)
                    && (b.part_maker == filter_cfg.maker_code_a
                        || b.part_maker == filter_cfg.maker_code_b)) begin
                idx = {b.order_year == FGPS_LAST_YEAR, b.supplier_nation, b.part_category};
                group_hit[idx]   = 1'b1;
                // cost above revenue wraps at 64 bits
                group_total[idx] = group_total[idx] + {32'd0, b.revenue}
                                   - {32'd0, b.supply_cost};
                rows_kept++;
            end
        end else begin
            // read: table untouched, index decoded even for an empty entry
            idx                = b.read_index;
            grp.entry_valid    = group_hit[idx];
            grp.group_year     = FGPS_YEAR_OUT_0 + 11'(idx[9]);
            grp.group_nation   = idx[8:4];
            grp.group_category = idx[3:0];
            grp.profit_sum     = group_hit[idx] ? group_total[idx] : 64'd0;
            expected_groups.push_back(grp);
            reads_seen++;
        end
    endtask

    task automatic check_group(input t_out_beat got);
        t_out_beat want;
        if (expected_groups.size() == 0) begin
            $error("result beat with no read outstanding: %p", got);
            mismatches++;
        end else begin
            want = expected_groups.pop_front();
            groups_checked++;
            if (got.entry_valid !== want.entry_valid) begin
                $error("entry_valid expected %0d got %0d", want.entry_valid, got.entry_valid);
                mismatches++;
            end
            if (got.group_year !== want.group_year) begin
                $error("group_year expected %0d got %0d", want.group_year, got.group_year);
                mismatches++;
            end
            if (got.group_nation !== want.group_nation) begin
                $error("group_nation expected %0d got %0d", want.group_nation, got.group_nation);
                mismatches++;
            end
            if (got.group_category !== want.group_category) begin
                $error("group_category expected %0d got %0d",
                       want.group_category, got.group_category);
                mismatches++;
            end
            if (got.profit_sum !== want.profit_sum) begin
                $error("profit_sum expected %h got %h", want.profit_sum, got.profit_sum);
                mismatches++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // input side: accept at the rising edge, drive at the falling edge
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        beat_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            // predict before checking so a same-edge result would still line up
            if (i_in_valid && !o_in_stall)
                fold_beat(i_in_beat);
            if (o_out_valid && !i_out_stall)
                check_group(o_out_beat);
        end
    end

    // valid only drops or moves on after a beat was taken, never on stall
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_beats.size() != 0) begin
                i_in_beat  <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 99) < gap_pct)
                    gap_left <= $urandom_range(1, 6);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall comes in bursts of random length
    always @(negedge i_clk) begin
        stall_next = stall_left;
        if (stall_next != 0)
            stall_next = stall_next - 1;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_next = $urandom_range(1, 6);
        stall_left  <= stall_next;
        i_out_stall <= (stall_next != 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads still outstanding",
                     cycle_count, expected_groups.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // config port
    // ---------------------------------------------------------------------
    task automatic cfg_write(input logic [1:0] reg_idx, input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (reg_idx)
            FGPS_REG_REGION:  filter_cfg.region_code  = value;
            FGPS_REG_MAKER_A: filter_cfg.maker_code_a = value;
            FGPS_REG_MAKER_B: filter_cfg.maker_code_b = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_filter(input logic [7:0] region, input logic [7:0] maker_a,
                                  input logic [7:0] maker_b);
        cfg_write(FGPS_REG_REGION, region);
        cfg_write(FGPS_REG_MAKER_A, maker_a);
        cfg_write(FGPS_REG_MAKER_B, maker_b);
        settings_used++;
    endtask

    // wait for every beat to go in and every read to come back, then let
    // any trailing rows drain out of the back end
    task automatic settle();
        while (pending_beats.size() != 0 || i_in_valid || expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // beat builders
    // ---------------------------------------------------------------------
    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // keep half the traffic on a few groups so sums build up and collide
    function automatic logic [4:0] hot_nation();
        return $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [3:0] hot_category();
        return $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    endfunction

    function automatic t_in_beat noise_beat();
        logic [127:0] raw;
        t_in_beat     b;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b   = raw[$bits(t_in_beat)-1:0];
        return b;
    endfunction

    // row that matches the current region, with random read_index as filler
    function automatic t_in_beat row_beat(input logic [15:0] year, input logic [7:0] maker,
                                          input logic [4:0] nation, input logic [3:0] cat,
                                          input logic [31:0] rev, input logic [31:0] cost);
        t_in_beat b;
        b                 = noise_beat();
        b.func            = FGPS_FUNC_ACCUM;
        b.customer_region = filter_cfg.region_code;
        b.supplier_region = filter_cfg.region_code;
        b.order_year      = year;
        b.part_maker      = maker;
        b.supplier_nation = nation;
        b.part_category   = cat;
        b.revenue         = rev;
        b.supply_cost     = cost;
        return b;
    endfunction

    // read with junk in the row fields, which must be ignored
    function automatic t_in_beat read_beat(input logic [9:0] idx);
        t_in_beat b;
        b            = noise_beat();
        b.func       = FGPS_FUNC_READ;
        b.read_index = idx;
        return b;
    endfunction

    // mostly passing rows, some near misses, some noise, about a quarter reads
    function automatic t_in_beat random_item();
        t_in_beat    b;
        logic [15:0] yr;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll >= 72)
            return read_beat({1'($urandom_range(0, 1)), hot_nation(), hot_category()});
        if (roll >= 65)
            return noise_beat();
        b = row_beat($urandom_range(0, 1) ? FGPS_LAST_YEAR : FGPS_BASE_YEAR,
                     $urandom_range(0, 1) ? filter_cfg.maker_code_a : filter_cfg.maker_code_b,
                     hot_nation(), hot_category(), pick_amount(), pick_amount());
        if (roll >= 50) begin
            // near miss: exactly one filter term fails
            case (t_break'($urandom_range(0, 3)))
                BREAK_CUST: b.customer_region ^= 8'(1 << $urandom_range(0, 7));
                BREAK_SUPP: b.supplier_region ^= 8'(1 << $urandom_range(0, 7));
                BREAK_YEAR: begin
                    do begin
                        case ($urandom_range(0, 3))
                            0:       yr = 16'd1996;
                            1:       yr = 16'd1999;
                            default: yr = 16'($urandom);
                        endcase
                    end while (yr == FGPS_BASE_YEAR || yr == FGPS_LAST_YEAR);
                    b.order_year = yr;
                end
                BREAK_MAKER: begin
                    do b.part_maker = 8'($urandom);
                    while (b.part_maker == filter_cfg.maker_code_a
                           || b.part_maker == filter_cfg.maker_code_b);
                end
            endcase
        end
        return b;
    endfunction

    task automatic run_phase(input logic [7:0] region, input logic [7:0] maker_a,
                             input logic [7:0] maker_b, input int gaps, input int stalls);
        program_filter(region, maker_a, maker_b);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (PHASE_ITEMS) pending_beats.push_back(random_item());
        // the sender holds here until every read has come back
        settle();
    endtask

    // ---------------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------------
    initial begin
        for (int k = 0; k < FGPS_TABLE_DEPTH; k++) begin
            group_hit[k]   = 1'b0;
            group_total[k] = 64'd0;
        end
        filter_cfg = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; written while the table clear is still running
        program_filter(8'hFF, 8'h00, 8'hFF);
        gap_pct   = 20;
        stall_pct = 20;
        // freshly cleared corners
        pending_beats.push_back(read_beat(10'd0));
        pending_beats.push_back(read_beat(10'd1023));
        // largest profit, then read straight after the write
        pending_beats.push_back(row_beat(FGPS_BASE_YEAR, 8'h00, 5'd0, 4'd0,
                                         32'hFFFF_FFFF, 32'd0));
        pending_beats.push_back(read_beat(10'd0));
        // cost above revenue wraps, top corner of the table, back to back
        pending_beats.push_back(row_beat(FGPS_LAST_YEAR, 8'hFF, 5'd31, 4'd15,
                                         32'd0, 32'hFFFF_FFFF));
        pending_beats.push_back(row_beat(FGPS_LAST_YEAR, 8'hFF, 5'd31, 4'd15, 32'd5, 32'd3));
        pending_beats.push_back(read_beat(10'd1023));
        // rows failing one term each, all aimed at entry 0
        pending_beats.push_back(row_beat(FGPS_BASE_YEAR, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats[$].customer_region = 8'hFE;
        pending_beats.push_back(row_beat(FGPS_BASE_YEAR, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats[$].supplier_region = 8'h7F;
        pending_beats.push_back(row_beat(16'd1996, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats.push_back(row_beat(16'd1999, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats.push_back(row_beat(16'd0, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats.push_back(row_beat(16'hFFFF, 8'h00, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats.push_back(row_beat(FGPS_BASE_YEAR, 8'h80, 5'd0, 4'd0, 32'd9, 32'd1));
        pending_beats.push_back(read_beat(10'd0));
        // read whose row fields would pass must leave the table alone
        pending_beats.push_back(row_beat(FGPS_LAST_YEAR, 8'hFF, 5'd0, 4'd0,
                                         32'hFFFF_FFFF, 32'd0));
        pending_beats[$].func       = FGPS_FUNC_READ;
        pending_beats[$].read_index = 10'd512;
        pending_beats.push_back(read_beat(10'd512));
        // year 1998 half, two rows into one entry with no gap
        pending_beats.push_back(row_beat(FGPS_LAST_YEAR, 8'h00, 5'd0, 4'd0, 32'd100, 32'd1));
        pending_beats.push_back(row_beat(FGPS_LAST_YEAR, 8'hFF, 5'd0, 4'd0, 32'd1, 32'd100));
        pending_beats.push_back(read_beat(10'd512));
        // empty entry at an odd index still decodes
        pending_beats.push_back(read_beat(10'h1F5));
        // row carrying a read_index that must be ignored
        pending_beats.push_back(row_beat(FGPS_BASE_YEAR, 8'h00, 5'd5, 4'd3, 32'd77, 32'd7));
        pending_beats[$].read_index = 10'd0;
        pending_beats.push_back(read_beat(10'd83));
        settle();

        // random part over several filter settings
        run_phase(8'h00, 8'h00, 8'h00, 30, 30);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 0, 0);
        run_phase(8'hFF, 8'hFF, 8'h00, 50, 50);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 25, 40);
        // last part runs with no idling on either side
        run_phase(8'h01, 8'h80, 8'h7F, 0, 0);

        repeat (40) @(posedge i_clk);
        $display("covered %0d rows (%0d through the filter) and %0d reads under %0d settings",
                 rows_seen, rows_kept, reads_seen, settings_used);
        $display("%0d group reads compared, %0d mismatches", groups_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
